// ===== hw/rtl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Types and character constants shared by the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    // terminal characters
    localparam logic [7:0] CH_BEL   = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ETX   = 8'd3;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_UC_C  = 8'd67;

    // request commands
    localparam logic CMD_TYPE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECHO   = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_PROMPT = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    // result sequences that one request can start
    typedef enum logic [2:0] {
        JOB_ECHO,
        JOB_EOL,
        JOB_ERASE,
        JOB_INTR,
        JOB_READ
    } t_job;

    // work descriptor handed from decode to the result sequencer
    typedef struct packed {
        t_job       job;
        logic [7:0] data;
        logic [7:0] len;
        logic       oor;
    } t_desc;

endpackage

// ===== hw/rtl/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical-mode line editor for a terminal byte stream.
// ----------------------------------------------------------------------------
// A request is accepted in every cycle as long as the result side keeps up.
// Each request passes a decode stage that updates the line count, writes
// printable characters into the line RAM or starts a RAM read, then a pending
// stage, then the result sequencer that drives the output ports. The first
// result of a request reaches the output ports after the pending register and
// the sequencer register. A request gives 0, 1, 3 or 5 results and the
// sequencer puts out one result per cycle while i_stall is low; while the
// pending stage holds a request and the sequencer holds one whose last
// result is not being handed over, o_stall is high. Requests that give no
// result leave the pipeline at decode. Read data is valid until further
// bytes are typed; the line RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
    parameter int LINE_SIZE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_byte_value,
    input  logic [7:0] i_read_index,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [7:0] o_line_length,
    output logic       o_last
);

    import tle_pkg::*;

    localparam int AW = $clog2(LINE_SIZE);
    localparam int IW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [AW-1:0] CountMax = AW'(LINE_SIZE - 1);

    // registers and next values
    logic [AW-1:0] r_count,     n_count;
    logic          r_swallow,   n_swallow;
    logic          r_p_valid,   n_p_valid;
    t_desc         r_p,         n_p;
    logic          r_e_valid,   n_e_valid;
    t_desc         r_e,         n_e;
    logic [2:0]    r_step,      n_step;

    // handshake and flow
    logic acc;
    logic e_last;
    logic e_done;
    logic e_free;
    logic p_move;

    // decode results
    logic          has_job;
    t_desc         dec;
    logic          wr_en;
    logic          rd_en;
    logic [IW-1:0] idx_w;
    logic          idx_oor;
    logic [7:0]    rd_data;
    logic [2:0]    e_total;

    // line store
    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_SIZE)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count),
        .i_wr_data (i_byte_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_w[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // flow control between the stages
    assign e_done  = r_e_valid && !i_stall && e_last;
    assign e_free  = !r_e_valid || e_done;
    assign p_move  = r_p_valid && e_free;
    assign o_stall = r_p_valid && !e_free;
    assign acc     = i_valid && !o_stall;

    // read index range check
    assign idx_w   = IW'(i_read_index);
    assign idx_oor = (idx_w >= IW'(LINE_SIZE));

    // request decode and line state update
    always_comb begin
        n_count   = r_count;
        n_swallow = r_swallow;
        has_job   = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        dec.job   = JOB_ECHO;
        dec.data  = i_byte_value;
        dec.len   = 8'd0;
        dec.oor   = idx_oor;
        if (acc) begin
            if (i_cmd == CMD_READ) begin
                has_job = 1'b1;
                rd_en   = !idx_oor;
                dec.job = JOB_READ;
            end else if (i_byte_value == CH_LF && r_swallow) begin
                n_swallow = 1'b0;
            end else begin
                n_swallow = 1'b0;
                if (i_byte_value == CH_CR || i_byte_value == CH_LF) begin
                    has_job   = 1'b1;
                    dec.job   = JOB_EOL;
                    dec.len   = 8'(r_count);
                    n_swallow = (i_byte_value == CH_CR);
                    n_count   = '0;
                end else if (i_byte_value == CH_BS || i_byte_value == CH_DEL) begin
                    if (r_count != '0) begin
                        has_job = 1'b1;
                        dec.job = JOB_ERASE;
                        n_count = r_count - AW'(1);
                    end
                end else if (i_byte_value == CH_ETX) begin
                    has_job = 1'b1;
                    dec.job = JOB_INTR;
                    n_count = '0;
                end else if (i_byte_value inside {[CH_SPACE:CH_TILDE]}) begin
                    has_job = 1'b1;
                    dec.job = JOB_ECHO;
                    if (r_count != CountMax) begin
                        wr_en   = 1'b1;
                        n_count = r_count + AW'(1);
                    end else begin
                        dec.data = CH_BEL;
                    end
                end
            end
        end
    end

    // pending stage
    always_comb begin
        n_p_valid = r_p_valid;
        n_p       = r_p;
        if (p_move) begin
            n_p_valid = 1'b0;
        end
        if (acc && has_job) begin
            n_p_valid = 1'b1;
            n_p       = dec;
        end
    end

    // result sequencer state
    always_comb begin
        n_e_valid = r_e_valid;
        n_e       = r_e;
        n_step    = r_step;
        if (r_e_valid && !i_stall) begin
            if (e_last) begin
                n_e_valid = 1'b0;
            end else begin
                n_step = r_step + 3'd1;
            end
        end
        if (p_move) begin
            n_e_valid = 1'b1;
            n_e       = r_p;
            n_step    = 3'd0;
            if (r_p.job == JOB_READ) begin
                n_e.data = r_p.oor ? 8'd0 : rd_data;
            end
        end
    end

    // result fields for the current step
    always_comb begin
        o_kind        = KIND_ECHO;
        o_data        = r_e.data;
        o_line_length = 8'd0;
        e_total       = 3'd1;
        case (r_e.job)
            JOB_ECHO: begin
                e_total = 3'd1;
            end
            JOB_READ: begin
                e_total = 3'd1;
                o_kind  = KIND_READ;
            end
            JOB_EOL: begin
                e_total = 3'd3;
                case (r_step)
                    3'd0: o_data = CH_CR;
                    3'd1: o_data = CH_LF;
                    default: begin
                        o_kind        = KIND_LINE;
                        o_data        = 8'd0;
                        o_line_length = r_e.len;
                    end
                endcase
            end
            JOB_ERASE: begin
                e_total = 3'd3;
                o_data  = (r_step == 3'd1) ? CH_SPACE : CH_BS;
            end
            JOB_INTR: begin
                e_total = 3'd5;
                case (r_step)
                    3'd0: o_data = CH_CARET;
                    3'd1: o_data = CH_UC_C;
                    3'd2: o_data = CH_CR;
                    3'd3: o_data = CH_LF;
                    default: begin
                        o_kind = KIND_PROMPT;
                        o_data = 8'd0;
                    end
                endcase
            end
            default: begin
                e_total = 3'd1;
            end
        endcase
    end

    assign e_last  = (r_step == e_total - 3'd1);
    assign o_valid = r_e_valid;
    assign o_last  = e_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_swallow <= 1'b0;
            r_p_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_step    <= 3'd0;
        end else begin
            r_count   <= n_count;
            r_swallow <= n_swallow;
            r_p_valid <= n_p_valid;
            r_e_valid <= n_e_valid;
            r_step    <= n_step;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_e <= n_e;
    end

`ifndef SYNTH
    // line count never passes the last usable position
    ast_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountMax)
        else $error("line count out of range");

    // sequencer step stays inside the current result sequence
    ast_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_step < e_total))
        else $error("result step beyond sequence length");

    // a request that starts a sequence is held in the pending stage
    ast_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && has_job) |=> r_p_valid)
        else $error("accepted request lost at decode");

    // a pending descriptor is kept until the sequencer takes it
    ast_pending_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !p_move) |=> (r_p_valid && $stable(r_p)))
        else $error("pending descriptor dropped or changed");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal line editor: a queue of typed bytes and
// read requests feeds a clocked driver, a line-discipline predictor builds the
// expected echo, line, prompt and read results, and a clocked monitor compares
// every result with the oldest expected one while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import tle_pkg::*;

    localparam int LINE_SIZE    = 256;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 410;

    typedef struct packed {
        logic       cmd;
        logic [7:0] b;
        logic [7:0] idx;
    } t_request;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] len;
        logic       last;
    } t_result;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_cmd        = 1'b0;
    logic [7:0] i_byte_value = 8'd0;
    logic [7:0] i_read_index = 8'd0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data;
    logic [7:0] o_line_length;
    logic       o_last;

    terminal_line_editor #(.LINE_SIZE(LINE_SIZE)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_byte_value  (i_byte_value),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data        (o_data),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_request   typed_queue[$];
    t_result    awaited_results[$];
    t_result    step_results[$];

    // predicted editor state
    logic [7:0] line_mem[LINE_SIZE];
    logic [8:0] line_len   = 9'd0;
    logic       lf_pending = 1'b0;

    // generator's view of the line, used to keep reads on written entries
    int         gen_len    = 0;
    int         gen_top    = 0;
    int         gen_counted = 0;

    int         cycle      = 0;
    int         n_req      = 0;
    int         gap_left   = 0;
    int         wait_left  = 0;
    int         hold_left  = 0;
    bit         hold_fired = 1'b0;
    int         mismatches = 0;

    function automatic void add_result(t_kind k, logic [7:0] d, logic [7:0] n);
        t_result res;
        res.kind = k;
        res.data = d;
        res.len  = n;
        res.last = 1'b0;
        step_results.push_back(res);
    endfunction

    // line discipline: expected results of one accepted request
    function automatic void predict_response(t_request r);
        step_results.delete();
        if (r.cmd == CMD_READ) begin
            add_result(KIND_READ, line_mem[r.idx], 8'd0);
        end else if (r.b == CH_LF && lf_pending) begin
            lf_pending = 1'b0;
        end else begin
            lf_pending = (r.b == CH_CR);
            if (r.b == CH_CR || r.b == CH_LF) begin
                add_result(KIND_ECHO, CH_CR, 8'd0);
                add_result(KIND_ECHO, CH_LF, 8'd0);
                add_result(KIND_LINE, 8'd0, line_len[7:0]);
                line_len = 9'd0;
            end else if (r.b == CH_BS || r.b == CH_DEL) begin
                if (line_len != 9'd0) begin
                    line_len = line_len - 9'd1;
                    add_result(KIND_ECHO, CH_BS, 8'd0);
                    add_result(KIND_ECHO, CH_SPACE, 8'd0);
                    add_result(KIND_ECHO, CH_BS, 8'd0);
                end
            end else if (r.b == CH_ETX) begin
                line_len = 9'd0;
                add_result(KIND_ECHO, CH_CARET, 8'd0);
                add_result(KIND_ECHO, CH_UC_C, 8'd0);
                add_result(KIND_ECHO, CH_CR, 8'd0);
                add_result(KIND_ECHO, CH_LF, 8'd0);
                add_result(KIND_PROMPT, 8'd0, 8'd0);
            end else if (r.b >= CH_SPACE && r.b <= CH_TILDE) begin
                if (line_len + 9'd1 < LINE_SIZE) begin
                    line_mem[line_len[7:0]] = r.b;
                    line_len = line_len + 9'd1;
                    add_result(KIND_ECHO, r.b, 8'd0);
                end else begin
                    add_result(KIND_ECHO, CH_BEL, 8'd0);
                end
            end
        end
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            awaited_results.push_back(step_results[i]);
    endfunction

    // queue one request and track where the line has written
    function automatic void add_request(logic cmd, logic [7:0] b, logic [7:0] idx);
        t_request r;
        r.cmd = cmd;
        r.b   = b;
        r.idx = idx;
        typed_queue.push_back(r);
        if (cmd == CMD_READ) begin
            gen_counted++;
        end else if (b == CH_CR || b == CH_LF || b == CH_ETX) begin
            gen_len = 0;
            gen_counted++;
        end else if (b == CH_BS || b == CH_DEL) begin
            if (gen_len != 0)
                gen_len--;
            gen_counted++;
        end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            if (gen_len + 1 < LINE_SIZE) begin
                gen_len++;
                if (gen_len > gen_top)
                    gen_top = gen_len;
            end
            gen_counted++;
        end
    endfunction

    function automatic void add_typed(logic [7:0] b);
        add_request(CMD_TYPE, b, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_printable();
        add_typed(8'($urandom_range(32, 126)));
    endfunction

    // reads only touch entries that some line has already written
    function automatic void add_read();
        if (gen_top > 0)
            add_request(CMD_READ, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, gen_top - 1)));
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // request driver
    always @(posedge i_clk) begin : driver
        int       w;
        t_request r;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (i_valid && !o_stall) begin
            r.cmd = i_cmd;
            r.b   = i_byte_value;
            r.idx = i_read_index;
            predict_response(r);
            n_req <= n_req + 1;
            w = draw_wait(hold_left != 0 || (cycle / 256) % 3 == 0);
            if (w == 0 && typed_queue.size() != 0) begin
                r = typed_queue.pop_front();
                i_cmd        <= r.cmd;
                i_byte_value <= r.b;
                i_read_index <= r.idx;
            end else begin
                i_valid  <= 1'b0;
                gap_left <= (w == 0) ? 0 : w - 1;
            end
        end else if (!i_valid) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (typed_queue.size() != 0) begin
                r = typed_queue.pop_front();
                i_cmd        <= r.cmd;
                i_byte_value <= r.b;
                i_read_index <= r.idx;
                i_valid      <= 1'b1;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin : monitor
        t_result exp;
        int      w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d data %0d len %0d last %0d",
                                 o_kind, o_data, o_line_length, o_last);
                end else begin
                    exp = awaited_results.pop_front();
                    if (o_kind !== exp.kind || o_data !== exp.data ||
                        o_line_length !== exp.len || o_last !== exp.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected kind %0d data %0d len %0d last %0d",
                                     exp.kind, exp.data, exp.len, exp.last,
                                     ", got kind %0d data %0d len %0d last %0d",
                                     o_kind, o_data, o_line_length, o_last);
                    end
                end
            end
            // one long hold-off so the block backs up into its request side
            if (!hold_fired && n_req >= HOLD_AT) begin
                hold_fired <= 1'b1;
                hold_left  <= HOLD_LEN;
                i_stall    <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (wait_left != 0) begin
                wait_left <= wait_left - 1;
                i_stall   <= 1'b1;
            end else if (o_valid && !i_stall) begin
                w = draw_wait((cycle / 192) % 3 == 1);
                i_stall   <= (w != 0);
                wait_left <= (w == 0) ? 0 : w - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int n;
        int pick;
        bit long_done;
        long_done = 1'b0;

        // directed: ignored bytes, erase on empty line, printable extremes, reads
        add_typed(CH_BS);
        add_typed(CH_DEL);
        add_typed(8'd0);
        add_typed(8'd255);
        add_typed(8'd31);
        add_typed(8'd128);
        add_typed(CH_SPACE);
        add_typed(CH_TILDE);
        add_typed(8'd65);
        add_request(CMD_READ, 8'd0, 8'd0);
        add_request(CMD_READ, 8'd255, 8'd1);
        add_request(CMD_READ, 8'd170, 8'd2);
        add_typed(CH_DEL);
        add_typed(CH_BS);
        // cr ends the line, the following lf is swallowed, a lone lf ends an empty line
        add_typed(CH_CR);
        add_typed(CH_LF);
        add_typed(CH_LF);
        // another byte between cr and lf cancels the swallow
        add_typed(CH_CR);
        add_typed(8'd120);
        add_typed(CH_LF);
        // a read between cr and lf keeps the swallow
        add_typed(CH_CR);
        add_request(CMD_READ, 8'd85, 8'd0);
        add_typed(CH_LF);
        // ctrl-c with a partial line
        add_typed(8'd113);
        add_typed(CH_ETX);
        add_request(CMD_READ, 8'd0, 8'd2);

        // random sequences, mostly well-formed lines
        gen_counted = 0;
        while (gen_counted < RANDOM_ITEMS) begin
            if (!long_done && gen_counted >= 60) begin
                // fill the line to the top, ring the bell, erase and refill
                long_done = 1'b1;
                for (int i = 0; i < LINE_SIZE + 2; i++)
                    add_printable();
                add_typed(CH_DEL);
                add_printable();
                add_printable();
                add_typed(CH_CR);
                add_request(CMD_READ, 8'($urandom_range(0, 255)), 8'(LINE_SIZE - 2));
                add_read();
                add_read();
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                n = $urandom_range(0, 12);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 5) == 0)
                        add_typed($urandom_range(0, 1) ? CH_BS : CH_DEL);
                    else
                        add_printable();
                end
                case ($urandom_range(0, 2))
                    0: add_typed(CH_CR);
                    1: add_typed(CH_LF);
                    default: begin
                        add_typed(CH_CR);
                        add_typed(CH_LF);
                    end
                endcase
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    add_read();
            end else if (pick == 6) begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    add_printable();
                add_typed(CH_ETX);
            end else if (pick == 7) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_typed(8'($urandom_range(0, 255)));
            end else if (pick == 8) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_read();
            end else begin
                case ($urandom_range(0, 2))
                    0: add_typed(CH_LF);
                    1: begin
                        add_typed(CH_CR);
                        add_typed(CH_CR);
                    end
                    default: begin
                        n = $urandom_range(1, 4);
                        for (int i = 0; i < n; i++)
                            add_typed(CH_BS);
                    end
                endcase
            end
        end

        // reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests, then all results, then let the pipe settle
        @(posedge i_clk);
        while (typed_queue.size() != 0 || i_valid)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += awaited_results.size();

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
